// File: hdl/pmbc_pkg.sv
// Package with the shared types and constants of the pairing-mode button controller.
package pmbc_pkg;

  // Configuration register geometry.
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_INTERVAL = 2'd2;

  // Register values after reset, in ticks.
  localparam logic [CFG_W-1:0] HOLD_TIME_RST      = 16'd3000;
  localparam logic [CFG_W-1:0] PAIR_LIMIT_RST     = 16'd30000;
  localparam logic [CFG_W-1:0] FLASH_INTERVAL_RST = 16'd500;

  // Operating modes.
  typedef enum logic [1:0] {
    MODE_WAITING = 2'd0,
    MODE_PAIRING = 2'd1,
    MODE_PAIRED  = 2'd2
  } mode_e;

  // Current configuration as seen by the tick logic.
  typedef struct packed {
    logic [CFG_W-1:0] hold_time;
    logic [CFG_W-1:0] pair_limit;
    logic [CFG_W-1:0] flash_interval;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    mode_e mode;
    logic  red_led;
    logic  blue_led;
    logic  advertise_start;
    logic  advertise_stop;
  } result_t;

endpackage

// File: hdl/pmbc_tick_if.sv
// Interface of the tick input channel.
interface pmbc_tick_if;
  logic valid;
  logic ready;
  logic button_down;
  logic link_connect;
  logic link_disconnect;

  modport source (output valid, output button_down, output link_connect,
                  output link_disconnect, input ready);
  modport sink (input valid, input button_down, input link_connect,
                input link_disconnect, output ready);
endinterface

// File: hdl/pmbc_result_if.sv
// Interface of the result output channel.
interface pmbc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       red_led;
  logic       blue_led;
  logic       advertise_start;
  logic       advertise_stop;

  modport source (output valid, output mode, output red_led, output blue_led,
                  output advertise_start, output advertise_stop, input ready);
  modport sink (input valid, input mode, input red_led, input blue_led,
                input advertise_start, input advertise_stop, output ready);
endinterface

// File: hdl/pairing_mode_button_controller_core.sv
// Pairing-mode button controller: one tick transaction in, one result transaction out.
//
// Usage: each transaction on tick_i is one millisecond tick carrying the
// sampled button level and the link connect and disconnect pulses. For each
// accepted tick the block returns one transaction on result_o with the mode
// after that tick, both LED levels and the advertising start and stop pulses.
// The user must write the three timing registers through the cfg_* port only while no
// tick is in flight; the block itself does not enforce this.
// The result of a tick is registered and visible on result_o in the cycle after
// the tick transaction is accepted. Throughput: one tick per cycle while the
// receiver keeps taking results, set by the single result register that the state update writes in the same cycle.
// Stall: while a result waits on result_o, tick_i stays ready only if the
// receiver takes that result in the same cycle; otherwise the tick waits.
// Reset: rst_ni clears the mode to waiting, turns both LEDs off, loads the
// register defaults (hold 3000, timeout 30000, flash 500 ticks) and sets the
// flash counter to its maximum so the first pairing flash comes at once.
module pairing_mode_button_controller_core
  import pmbc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pmbc_tick_if.sink            tick_i,
  pmbc_result_if.source        result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t    cfg;
  result_t res_next;
  result_t res_q;
  logic    out_valid_q, out_valid_d;
  logic    tick_fire;

  pmbc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pmbc_tick #(
    .TIMER_BITS (TIMER_BITS)
  ) u_tick (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (tick_fire),
    .button_down_i     (tick_i.button_down),
    .link_connect_i    (tick_i.link_connect),
    .link_disconnect_i (tick_i.link_disconnect),
    .cfg_i             (cfg),
    .res_o             (res_next)
  );

  // A tick is taken whenever the result register is free or being drained.
  assign tick_i.ready = !out_valid_q || result_o.ready;
  assign tick_fire    = tick_i.valid && tick_i.ready;

  // Result register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (tick_fire) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      res_q <= res_next;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.mode            = res_q.mode;
  assign result_o.red_led         = res_q.red_led;
  assign result_o.blue_led        = res_q.blue_led;
  assign result_o.advertise_start = res_q.advertise_start;
  assign result_o.advertise_stop  = res_q.advertise_stop;

`ifndef SYNTHESIS
  // Advertising only starts on entry to pairing, with the red LED off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.advertise_start) |->
      (res_q.mode == MODE_PAIRING && !res_q.red_led))
    else $error("advertise_start outside pairing entry");

  // Start and stop never pulse in the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.advertise_start && res_q.advertise_stop))
    else $error("advertise_start and advertise_stop together");

  // A disconnect tick yields a paired result with a stop pulse next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_fire && tick_i.link_disconnect) |=>
      (out_valid_q && res_q.advertise_stop && res_q.mode == MODE_PAIRED))
    else $error("disconnect did not enter paired mode");
`endif

endmodule

// File: hdl/pmbc_cfg.sv
// Configuration register bank of the pairing-mode button controller.
module pmbc_cfg
  import pmbc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; an index past the last register is dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HOLD_TIME:      cfg_d.hold_time      = cfg_data_i;
        REG_PAIR_LIMIT:     cfg_d.pair_limit     = cfg_data_i;
        REG_FLASH_INTERVAL: cfg_d.flash_interval = cfg_data_i;
        default:            cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_time      <= HOLD_TIME_RST;
      cfg_q.pair_limit     <= PAIR_LIMIT_RST;
      cfg_q.flash_interval <= FLASH_INTERVAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/pmbc_tick.sv
// Mode state, elapsed counters and the per-tick update logic.
module pmbc_tick
  import pmbc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    button_down_i,
  input  logic    link_connect_i,
  input  logic    link_disconnect_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  mode_e                 mode_q, mode_d;
  logic                  btn_prev_q, btn_prev_d;
  logic [TIMER_BITS-1:0] hold_q, hold_d;
  logic [TIMER_BITS-1:0] pair_q, pair_d;
  logic [TIMER_BITS-1:0] flash_q, flash_d;
  logic [TIMER_BITS-1:0] linger_q, linger_d;
  logic                  armed_q, armed_d;
  logic                  client_q, client_d;
  logic                  red_q, red_d;
  logic                  blue_q, blue_d;

  logic [TIMER_BITS-1:0] hold_b, pair_b, flash_b, linger_b;
  logic                  hold_over, pair_over, flash_due, linger_over;
  logic                  btn_edge;
  logic                  start, stop;

  // Saturating increments of all elapsed counters.
  assign hold_b   = (hold_q   == TMAX) ? hold_q   : hold_q   + 1'b1;
  assign pair_b   = (pair_q   == TMAX) ? pair_q   : pair_q   + 1'b1;
  assign flash_b  = (flash_q  == TMAX) ? flash_q  : flash_q  + 1'b1;
  assign linger_b = (linger_q == TMAX) ? linger_q : linger_q + 1'b1;

  // Limit compares on the incremented counts, both sides zero-extended.
  assign hold_over   = CMP_W'(hold_b)   >  CMP_W'(cfg_i.hold_time);
  assign pair_over   = CMP_W'(pair_b)   >  CMP_W'(cfg_i.pair_limit);
  assign flash_due   = CMP_W'(flash_b)  >= CMP_W'(cfg_i.flash_interval);
  assign linger_over = CMP_W'(linger_b) >  CMP_W'(cfg_i.hold_time);

  assign btn_edge = btn_prev_q != button_down_i;

  // Next state for one tick.
  always_comb begin
    mode_d     = mode_q;
    btn_prev_d = btn_prev_q;
    hold_d     = hold_b;
    pair_d     = pair_b;
    flash_d    = flash_b;
    linger_d   = linger_b;
    armed_d    = armed_q;
    client_d   = client_q;
    red_d      = red_q;
    blue_d     = blue_q;
    start      = 1'b0;
    stop       = 1'b0;

    // Link events: connect first, then disconnect.
    if (link_connect_i) begin
      client_d = 1'b1;
      blue_d   = 1'b1;
    end
    if (link_disconnect_i) begin
      client_d = 1'b0;
      mode_d   = MODE_PAIRED;
      armed_d  = 1'b0;
    end

    unique case (mode_d)
      MODE_WAITING: begin
        if (btn_edge) begin
          btn_prev_d = button_down_i;
          if (button_down_i) begin
            hold_d = '0;
          end
        end else if (button_down_i && hold_over) begin
          mode_d = MODE_PAIRING;
          red_d  = 1'b0;
          pair_d = '0;
          hold_d = '0;
          start  = 1'b1;
        end
      end
      MODE_PAIRING: begin
        if (!client_d) begin
          if (flash_due) begin
            blue_d  = ~blue_d;
            flash_d = '0;
          end
          if (btn_edge) begin
            btn_prev_d = button_down_i;
            if (button_down_i) begin
              hold_d = '0;
            end
          end else if ((button_down_i && hold_over) || pair_over) begin
            mode_d = MODE_WAITING;
            red_d  = 1'b1;
            blue_d = 1'b0;
            hold_d = '0;
            stop   = 1'b1;
          end
        end
      end
      default: begin
        // Paired: stop advertising once, then linger before waiting again.
        if (!armed_d) begin
          stop     = 1'b1;
          armed_d  = 1'b1;
          linger_d = '0;
        end else if (linger_over) begin
          blue_d = 1'b0;
          mode_d = MODE_WAITING;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_WAITING;
      btn_prev_q <= 1'b0;
      hold_q     <= '0;
      pair_q     <= '0;
      flash_q    <= TMAX;
      linger_q   <= '0;
      armed_q    <= 1'b0;
      client_q   <= 1'b0;
      red_q      <= 1'b0;
      blue_q     <= 1'b0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      btn_prev_q <= btn_prev_d;
      hold_q     <= hold_d;
      pair_q     <= pair_d;
      flash_q    <= flash_d;
      linger_q   <= linger_d;
      armed_q    <= armed_d;
      client_q   <= client_d;
      red_q      <= red_d;
      blue_q     <= blue_d;
    end
  end

  assign res_o.mode            = mode_d;
  assign res_o.red_led         = red_d;
  assign res_o.blue_led        = blue_d;
  assign res_o.advertise_start = start;
  assign res_o.advertise_stop  = stop;

endmodule

// File: verif/pmbc_behavior_monitor.sv
// Monitor that predicts each tick result of the pairing-mode button controller and compares it.
`timescale 1ns / 1ps

module pmbc_behavior_monitor
  import pmbc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pmbc_tick_if                 tick_i,
  pmbc_result_if               result_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   starts_o,
  output int                   stops_o
);

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // Local copy of the timing registers.
  logic [CFG_W-1:0] hold_time;
  logic [CFG_W-1:0] pair_timeout;
  logic [CFG_W-1:0] flash_interval;

  // Local copy of the controller state.
  mode_e                 mode_q;
  logic                  btn_q;
  logic [TIMER_BITS-1:0] hold_cnt;
  logic [TIMER_BITS-1:0] pair_cnt;
  logic [TIMER_BITS-1:0] flash_cnt;
  logic [TIMER_BITS-1:0] linger_cnt;
  logic                  linger_armed;
  logic                  client_q;
  logic                  red_q;
  logic                  blue_q;

  // Results owed by the block, oldest first.
  result_t owed_results[$];
  result_t want;
  int      error_cnt;
  int      checked_cnt;
  int      start_cnt;
  int      stop_cnt;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (v == TIMER_MAX) ? v : v + 1'b1;
  endfunction

  // Records a button edge; a press also restarts the hold count.
  function automatic logic take_edge(input logic btn);
    if (btn_q && !btn) begin
      btn_q = 1'b0;
      return 1'b1;
    end
    if (!btn_q && btn) begin
      btn_q    = 1'b1;
      hold_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the local state by one tick and returns the result it owes.
  function automatic result_t advance_tick(input logic btn, input logic conn, input logic disc);
    result_t r;
    logic    start;
    logic    stop;
    start      = 1'b0;
    stop       = 1'b0;
    hold_cnt   = sat_inc(hold_cnt);
    pair_cnt   = sat_inc(pair_cnt);
    flash_cnt  = sat_inc(flash_cnt);
    linger_cnt = sat_inc(linger_cnt);

    // Link events: connect first, then disconnect.
    if (conn) begin
      client_q = 1'b1;
      blue_q   = 1'b1;
    end
    if (disc) begin
      client_q     = 1'b0;
      mode_q       = MODE_PAIRED;
      linger_armed = 1'b0;
    end

    case (mode_q)
      MODE_WAITING: begin
        if (!take_edge(btn)) begin
          if (btn_q && btn && hold_cnt > hold_time) begin
            mode_q   = MODE_PAIRING;
            red_q    = 1'b0;
            pair_cnt = '0;
            hold_cnt = '0;
            start    = 1'b1;
          end
        end
      end
      MODE_PAIRING: begin
        // With a client connected, pairing just sits still.
        if (!client_q) begin
          if (flash_cnt >= flash_interval) begin
            blue_q    = ~blue_q;
            flash_cnt = '0;
          end
          if (!take_edge(btn)) begin
            if ((btn_q && btn && hold_cnt > hold_time) || pair_cnt > pair_timeout) begin
              mode_q   = MODE_WAITING;
              red_q    = 1'b1;
              blue_q   = 1'b0;
              hold_cnt = '0;
              stop     = 1'b1;
            end
          end
        end
      end
      default: begin
        if (!linger_armed) begin
          stop         = 1'b1;
          linger_armed = 1'b1;
          linger_cnt   = '0;
        end else if (linger_cnt > hold_time) begin
          blue_q = 1'b0;
          mode_q = MODE_WAITING;
        end
      end
    endcase

    r.mode            = mode_q;
    r.red_led         = red_q;
    r.blue_led        = blue_q;
    r.advertise_start = start;
    r.advertise_stop  = stop;
    return r;
  endfunction

  // Prints one line per mismatch (the first 40 only) and counts every one.
  task automatic report_mismatch(input string msg);
    error_cnt++;
    if (error_cnt <= 40) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Follows register writes, predicts accepted ticks and checks accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_time      = HOLD_TIME_RST;
      pair_timeout   = PAIR_LIMIT_RST;
      flash_interval = FLASH_INTERVAL_RST;
      mode_q         = MODE_WAITING;
      btn_q          = 1'b0;
      hold_cnt       = '0;
      pair_cnt       = '0;
      flash_cnt      = TIMER_MAX;
      linger_cnt     = '0;
      linger_armed   = 1'b0;
      client_q       = 1'b0;
      red_q          = 1'b0;
      blue_q         = 1'b0;
      owed_results.delete();
      error_cnt      = 0;
      checked_cnt    = 0;
      start_cnt      = 0;
      stop_cnt       = 0;
      errors_o      <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
      starts_o      <= 0;
      stops_o       <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HOLD_TIME:      hold_time      = cfg_data_i;
          REG_PAIR_LIMIT:     pair_timeout   = cfg_data_i;
          REG_FLASH_INTERVAL: flash_interval = cfg_data_i;
          default: ;
        endcase
      end

      if (tick_i.valid && tick_i.ready) begin
        owed_results.push_back(advance_tick(tick_i.button_down, tick_i.link_connect,
                                            tick_i.link_disconnect));
      end

      // Compare field by field against the oldest owed result.
      if (result_i.valid && result_i.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result transaction arrived with no tick waiting for one");
        end else begin
          want = owed_results.pop_front();
          checked_cnt++;
          if (want.advertise_start) start_cnt++;
          if (want.advertise_stop) stop_cnt++;
          if (result_i.mode !== want.mode)
            report_mismatch($sformatf("mode: expected %0d, got %0d", want.mode,
                                      result_i.mode));
          if (result_i.red_led !== want.red_led)
            report_mismatch($sformatf("red_led: expected %0d, got %0d", want.red_led,
                                      result_i.red_led));
          if (result_i.blue_led !== want.blue_led)
            report_mismatch($sformatf("blue_led: expected %0d, got %0d", want.blue_led,
                                      result_i.blue_led));
          if (result_i.advertise_start !== want.advertise_start)
            report_mismatch($sformatf("advertise_start: expected %0d, got %0d",
                                      want.advertise_start, result_i.advertise_start));
          if (result_i.advertise_stop !== want.advertise_stop)
            report_mismatch($sformatf("advertise_stop: expected %0d, got %0d",
                                      want.advertise_stop, result_i.advertise_stop));
        end
      end

      errors_o  <= error_cnt;
      pending_o <= owed_results.size();
      checked_o <= checked_cnt;
      starts_o  <= start_cnt;
      stops_o   <= stop_cnt;
    end
  end

endmodule

// File: verif/testbench.sv
// Top of the testbench: clock, reset, tick and register stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import pmbc_pkg::*;

  localparam int                   PHASE_TICKS  = 200;
  localparam int                   NUM_PHASES   = 7;
  localparam int                   LIMIT_CYCLES = 500000;
  localparam int                   LONG_STALL   = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  pmbc_tick_if   tick_ch ();
  pmbc_result_if result_ch ();

  int errors;
  int pending;
  int checked;
  int starts;
  int stops;

  int               sent = 0;
  int               settings_cnt = 0;
  int               cycle_cnt = 0;
  int               hold_off_req = 0;
  int               hold_off_served = 0;
  bit               no_gaps = 1'b0;
  logic [CFG_W-1:0] cur_hold;
  logic [CFG_W-1:0] cur_timeout;

  pairing_mode_button_controller_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  pmbc_behavior_monitor i_monitor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick_ch),
    .result_i   (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked),
    .starts_o   (starts),
    .stops_o    (stops)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop on a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Run did not finish within %0d cycles.", LIMIT_CYCLES);
      $display("pairing_mode_button_controller_core: mismatch");
      $finish;
    end
  end

  // Offers one tick transaction, with an optional idle gap in front of it.
  task automatic send_tick(input logic btn, input logic conn, input logic disc);
    int gap;
    int pick;
    gap = 0;
    if (!no_gaps) begin
      pick = $urandom_range(0, 99);
      if (pick >= 93) gap = $urandom_range(8, 40);
      else if (pick >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      tick_ch.valid           <= 1'b0;
      tick_ch.button_down     <= 1'($urandom_range(0, 1));
      tick_ch.link_connect    <= 1'($urandom_range(0, 1));
      tick_ch.link_disconnect <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
    tick_ch.valid           <= 1'b1;
    tick_ch.button_down     <= btn;
    tick_ch.link_connect    <= conn;
    tick_ch.link_disconnect <= disc;
    do @(posedge clk_i); while (!tick_ch.ready);
    sent++;
  endtask

  task automatic send_run(input logic btn, input logic conn, input logic disc, input int n);
    repeat (n) send_tick(btn, conn, disc);
  endtask

  // Stops offering ticks and waits until every owed result has come back.
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Writes all three timing registers, plus a write to the unused index.
  task automatic set_config(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] timeout,
                            input logic [CFG_W-1:0] flash);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_UNUSED;
    cfg_data <= CFG_W'($urandom_range(0, 65535));
    @(posedge clk_i);
    cfg_idx  <= REG_HOLD_TIME;
    cfg_data <= hold;
    @(posedge clk_i);
    cfg_idx  <= REG_PAIR_LIMIT;
    cfg_data <= timeout;
    @(posedge clk_i);
    cfg_idx  <= REG_FLASH_INTERVAL;
    cfg_data <= flash;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    cur_hold     = hold;
    cur_timeout  = timeout;
    settings_cnt++;
  endtask

  // Button presses and releases around the hold and timeout lengths, with rare
  // link events, mixed with stretches of fully random ticks.
  task automatic random_ticks(input int n_items);
    int stop_at;
    int kind;
    int len;
    int lim;
    bit btn;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        len = $urandom_range(1, 6);
        repeat (len) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
      end else begin
        btn = (kind < 62);
        if (btn) lim = (cur_hold > 36) ? 40 : cur_hold + 4;
        else if ($urandom_range(0, 3) == 0) lim = (cur_timeout > 56) ? 60 : cur_timeout + 4;
        else lim = 4;
        len = $urandom_range(1, lim);
        repeat (len) send_tick(btn, $urandom_range(0, 29) == 0, $urandom_range(0, 39) == 0);
      end
    end
  endtask

  // Receiver: bursts of ready, short and long stalls, and long hold-offs on request.
  initial begin
    int burst;
    int pick;
    int k;
    burst = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req > hold_off_served) begin
        result_ch.ready <= 1'b0;
        for (k = 0; k < LONG_STALL; k++) @(posedge clk_i);
        hold_off_served++;
        burst = 0;
      end else if (burst > 0) begin
        burst--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          result_ch.ready <= 1'b1;
          burst = $urandom_range(1, 20);
        end else if (pick < 85) begin
          result_ch.ready <= 1'b0;
          burst = $urandom_range(0, 2);
        end else if (pick < 95) begin
          result_ch.ready <= 1'($urandom_range(0, 1));
          burst = 0;
        end else begin
          result_ch.ready <= 1'b0;
          burst = $urandom_range(10, 40);
        end
      end
    end
  end

  // Main stimulus and verdict.
  initial begin
    int  hold_set[NUM_PHASES];
    int  timeout_set[NUM_PHASES];
    int  flash_set[NUM_PHASES];
    int  p;
    int  w;
    bit  drained;
    hold_set    = '{3, 1, 65535, 0, 0, 0, 2};
    timeout_set = '{20, 1, 65535, 0, 0, 0, 65535};
    flash_set   = '{2, 1, 65535, 0, 0, 0, 65535};
    rst_ni                  <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_idx                 <= REG_HOLD_TIME;
    cfg_data                <= '0;
    tick_ch.valid           <= 1'b0;
    tick_ch.button_down     <= 1'b0;
    tick_ch.link_connect    <= 1'b0;
    tick_ch.link_disconnect <= 1'b0;
    cur_hold                 = HOLD_TIME_RST;
    cur_timeout              = PAIR_LIMIT_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: press edge, connect in waiting, connect with disconnect,
    // and a press that paired mode ignores.
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    wait_drained();

    // Short timings: linger back to waiting, enter pairing, cancel by a long
    // hold, enter again and time out, then connect and disconnect in pairing.
    set_config(16'd1, 16'd3, 16'd0);
    send_run(1'b0, 1'b0, 1'b0, 2);
    send_run(1'b1, 1'b0, 1'b0, 5);
    send_tick(1'b0, 1'b0, 1'b0);
    send_run(1'b1, 1'b0, 1'b0, 3);
    send_run(1'b0, 1'b0, 1'b0, 4);
    send_run(1'b1, 1'b0, 1'b0, 3);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_run(1'b0, 1'b0, 1'b0, 3);
    wait_drained();

    // Random phases over a spread of register settings.
    hold_set[4]    = $urandom_range(1, 6);
    timeout_set[4] = $urandom_range(4, 40);
    flash_set[4]   = $urandom_range(0, 5);
    hold_set[5]    = $urandom_range(2, 12);
    timeout_set[5] = $urandom_range(8, 50);
    flash_set[5]   = $urandom_range(1, 8);
    for (p = 0; p < NUM_PHASES; p++) begin
      set_config(CFG_W'(hold_set[p]), CFG_W'(timeout_set[p]), CFG_W'(flash_set[p]));
      if (p == 0 || p == 4) begin
        // Keep offering ticks while the receiver holds off, so the block backs up.
        no_gaps = 1'b1;
        hold_off_req++;
      end else begin
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      random_ticks(PHASE_TICKS);
      wait_drained();
    end

    // Wait out the last results, then keep waiting a while for any stray one.
    tick_ch.valid <= 1'b0;
    drained = 1'b0;
    for (w = 0; w < 1000 && !drained; w++) begin
      @(posedge clk_i);
      drained = (pending == 0);
    end
    repeat (5) @(posedge clk_i);
    if (!drained) $display("%0d tick results never arrived.", pending);
    $display("Sent %0d ticks under %0d register settings; checked %0d results.",
             sent, settings_cnt, checked);
    $display("Pairing was entered %0d times and advertising was stopped %0d times.",
             starts, stops);
    if (errors == 0 && drained) begin
      $display("pairing_mode_button_controller_core: match");
    end else begin
      $display("pairing_mode_button_controller_core: mismatch");
    end
    $finish;
  end

endmodule
